// ----- sv/u8sf_pkg.sv -----
// u8sf_pkg: shared constants and types of the utf-8 sanitize filter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package u8sf_pkg;

   localparam int HOLD_DEPTH = 3;
   localparam int BURST_DEPTH = HOLD_DEPTH + 1;

   typedef logic [7:0] byte_type;

   // ascii range and the control bytes that survive
   localparam byte_type ASCII_MAX = 8'h7F;
   localparam byte_type SPACE_CHAR = 8'h20;
   localparam byte_type TAB_CHAR = 8'h09;
   localparam byte_type LF_CHAR = 8'h0A;
   localparam byte_type CR_CHAR = 8'h0D;

   // lead and continuation byte patterns
   localparam byte_type CONT_MASK = 8'hC0;
   localparam byte_type CONT_CODE = 8'h80;
   localparam byte_type LEAD2_MASK = 8'hE0;
   localparam byte_type LEAD2_CODE = 8'hC0;
   localparam byte_type LEAD3_MASK = 8'hF0;
   localparam byte_type LEAD3_CODE = 8'hE0;
   localparam byte_type LEAD4_MASK = 8'hF8;
   localparam byte_type LEAD4_CODE = 8'hF0;

   // total sequence lengths, zero means no sequence open
   localparam logic [2:0] SEQ_NONE = 3'd0;
   localparam logic [2:0] SEQ_LEN2 = 3'd2;
   localparam logic [2:0] SEQ_LEN3 = 3'd3;
   localparam logic [2:0] SEQ_LEN4 = 3'd4;

   // all responses caused by one request
   typedef struct packed {
      logic [BURST_DEPTH-1:0][7:0] data;
      logic [1:0]                  last_idx;
      logic                        has_byte;
      logic                        text_end;
   } burst_type;

endpackage

`default_nettype wire

// ----- sv/u8sf_req_if.sv -----
// u8sf_req_if: request channel of the utf-8 sanitize filter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface u8sf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

// ----- sv/u8sf_rsp_if.sv -----
// u8sf_rsp_if: response channel of the utf-8 sanitize filter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface u8sf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       has_byte;
   logic       run_last;
   logic       text_end;

   modport source (output valid, output out_byte, output has_byte, output run_last,
                   output text_end, input ready);
   modport sink (input valid, input out_byte, input has_byte, input run_last,
                 input text_end, output ready);
endinterface

`default_nettype wire

// ----- sv/u8sf_decode.sv -----
// u8sf_decode: sequence state and per-request classification into a burst
// depends on u8sf_pkg and u8sf_req_if
`timescale 1ns / 1ps
`default_nettype none

module u8sf_decode
   import u8sf_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   u8sf_req_if.sink   req,
   input  wire logic  slot_free,
   output logic       load,
   output burst_type  burst
);

   byte_type   held_ff [HOLD_DEPTH];
   logic [2:0] need_ff, need_in;
   logic [1:0] cnt_ff, cnt_in;

   byte_type   b;
   logic       open, cont, complete, extend, keep_ascii;
   logic       hold_en;
   logic [1:0] hold_idx;
   logic [1:0] emit_k;
   logic [2:0] n_bytes;
   logic       emits, accept;

   always_comb begin
      b = req.in_byte;
      open = (need_ff != SEQ_NONE);
      cont = ((b & CONT_MASK) == CONT_CODE);
      complete = open && cont && (({1'b0, cnt_ff} + 3'd1) >= need_ff);
      extend = open && cont && !complete;
      keep_ascii = !(open && cont) && (b <= ASCII_MAX) &&
                   (b >= SPACE_CHAR || b == LF_CHAR || b == CR_CHAR || b == TAB_CHAR);

      need_in = SEQ_NONE;
      cnt_in = 2'd0;
      hold_en = 1'b0;
      hold_idx = 2'd0;
      if (extend) begin
         need_in = need_ff;
         cnt_in = cnt_ff + 2'd1;
         hold_en = 1'b1;
         hold_idx = cnt_ff;
      end else if (!complete) begin
         // fresh start, also after a broken sequence
         if ((b & LEAD2_MASK) == LEAD2_CODE) begin
            need_in = SEQ_LEN2;
         end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            need_in = SEQ_LEN3;
         end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
            need_in = SEQ_LEN4;
         end
         if (need_in != SEQ_NONE) begin
            cnt_in = 2'd1;
            hold_en = 1'b1;
         end
      end
      if (req.in_last) begin
         need_in = SEQ_NONE;
         cnt_in = 2'd0;
      end

      emit_k = complete ? cnt_ff : 2'd0;
      n_bytes = complete ? ({1'b0, cnt_ff} + 3'd1) : (keep_ascii ? 3'd1 : 3'd0);
      emits = (n_bytes != 3'd0) || req.in_last;

      burst.has_byte = (n_bytes != 3'd0);
      burst.text_end = req.in_last;
      burst.last_idx = burst.has_byte ? 2'(n_bytes - 3'd1) : 2'd0;
      for (int i = 0; i < BURST_DEPTH; i++) begin
         if (!burst.has_byte) begin
            burst.data[i] = 8'h00;
         end else if (i < HOLD_DEPTH && 2'(i) < emit_k) begin
            burst.data[i] = held_ff[i];
         end else begin
            burst.data[i] = b;
         end
      end

      // requests that yield nothing pass even while the output is busy
      req.ready = !reset && (slot_free || !emits);
      accept = req.valid && req.ready;
      load = accept && emits;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         need_ff <= SEQ_NONE;
         cnt_ff <= 2'd0;
      end else if (accept) begin
         need_ff <= need_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && hold_en) begin
         held_ff[hold_idx] <= b;
      end
   end

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (need_ff == SEQ_NONE) |-> (cnt_ff == 2'd0))
      else $error("held bytes with no sequence open");

   a_open_count: assert property (@(posedge clock) disable iff (reset)
      (need_ff != SEQ_NONE) |-> (cnt_ff != 2'd0 && {1'b0, cnt_ff} < need_ff))
      else $error("held count out of range for open sequence");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |-> slot_free)
      else $error("burst loaded into a busy output slot");

endmodule

`default_nettype wire

// ----- sv/u8sf_serializer.sv -----
// u8sf_serializer: result register that hands out one response per ready cycle
// depends on u8sf_pkg and u8sf_rsp_if
`timescale 1ns / 1ps
`default_nettype none

module u8sf_serializer
   import u8sf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load,
   input  wire burst_type  burst,
   output logic            slot_free,
   u8sf_rsp_if.source      rsp
);

   burst_type  burst_ff;
   logic       busy_ff, busy_in;
   logic [1:0] idx_ff, idx_in;
   logic       fire, final_one;

   always_comb begin
      final_one = (idx_ff == burst_ff.last_idx);
      fire = busy_ff && rsp.ready;
      slot_free = !busy_ff || (fire && final_one);

      rsp.valid = busy_ff;
      rsp.out_byte = burst_ff.data[idx_ff];
      rsp.has_byte = burst_ff.has_byte;
      rsp.run_last = final_one;
      rsp.text_end = burst_ff.text_end && final_one;

      busy_in = busy_ff;
      idx_in = idx_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in = 2'd0;
      end else if (fire) begin
         if (final_one) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         burst_ff <= burst;
      end
   end

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff <= burst_ff.last_idx))
      else $error("response index past end of burst");

   a_marker_single: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !burst_ff.has_byte) |-> (burst_ff.text_end && burst_ff.last_idx == 2'd0))
      else $error("bare end marker is not a single final response");

   a_step_on: assert property (@(posedge clock) disable iff (reset)
      (fire && !final_one && !load) |=> (busy_ff && idx_ff == $past(idx_ff) + 2'd1))
      else $error("burst did not advance after a taken response");

endmodule

`default_nettype wire

// ----- sv/utf8_sanitize_filter.sv -----
// utf8_sanitize_filter: top level of the utf-8 sanitize filter
// depends on u8sf_pkg, u8sf_req_if, u8sf_rsp_if, u8sf_decode, u8sf_serializer
`timescale 1ns / 1ps
`default_nettype none

// Byte-stream utf-8 sanitizer. Each request carries one text byte and an
// end-of-text flag; each response carries one kept byte (or a bare end
// marker with has_byte low), run_last on the final response of its request
// and text_end on the final response of the text. Ascii 0x20-0x7F plus tab,
// newline and carriage return pass at once; 2/3/4-byte sequences are held
// and released whole when complete; broken or incomplete sequences, stray
// continuations, 0xF8-0xFF and other bytes below 0x20 are dropped. Overlong
// forms and surrogates are not checked. Rate: one request per cycle out of
// reset while it yields nothing or the result register is free. Decode is
// one combinational pass from the held-sequence state into a one-burst
// result register; a request yields 0 to 4 responses, which leave it one
// per cycle while the response side is ready, so a request that yields
// responses waits until the last response of the previous burst is taken,
// and may be taken in that same cycle; a stalled response side stalls it.

module utf8_sanitize_filter
   import u8sf_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   u8sf_req_if.sink    req_ch,
   u8sf_rsp_if.source  rsp_ch
);

   // burst handoff between decode and the result register
   burst_type burst;
   logic      load;
   logic      slot_free;

   // sequence state, byte classification and burst assembly
   u8sf_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .slot_free (slot_free),
      .load      (load),
      .burst     (burst)
   );

   // result register, drains one response per cycle while the response side is ready
   u8sf_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .burst     (burst),
      .slot_free (slot_free),
      .rsp       (rsp_ch)
   );

endmodule

`default_nettype wire
